// File: sv/bhsd_pkg.sv
package bhsd_pkg;

  localparam int MAX_CODE_BYTES = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CODES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGN_BITS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_MODE = 2'd3;

  localparam logic [2:0] MAX_BYTES_RST = 3'd5;
  localparam logic [8:0] HIGH_CODES_RST = 9'd64;
  localparam logic [1:0] SIGN_BITS_RST = 2'd0;
  localparam logic DELTA_MODE_RST = 1'b0;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  typedef struct packed {
    logic [2:0] max_bytes;
    logic [8:0] high_codes;
    logic [1:0] sign_bits;
    logic       delta_mode;
  } cfg_t;

  // one finished value handed from front to back
  typedef struct packed {
    logic [1:0]  status;
    logic        clr;
    logic [31:0] sum;
  } event_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic push;
    logic pop;
  } queue_status_t;

endpackage

// File: sv/bhsd_front.sv
module bhsd_front (
  input  logic                clk,
  input  logic                rst,
  input  bhsd_pkg::cfg_t      cfg,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                clear_delta,
  output logic                push,
  output bhsd_pkg::event_t    push_data
);
  import bhsd_pkg::*;

  logic [40:0] partial_sum;
  logic [32:0] digit_factor;
  logic [2:0]  bytes_seen;
  logic        clr_pend;

  logic [2:0]  nb;
  logic [8:0]  h;
  logic [8:0]  l;
  logic [40:0] prod;
  logic [40:0] sum_next;
  logic [41:0] df_mul;
  logic [2:0]  seen_next;
  logic        done;
  logic        clr_eff;

  always_comb begin
    if (cfg.max_bytes == 3'd0) begin
      nb = 3'd1;
    end else if (cfg.max_bytes > 3'(MAX_CODE_BYTES)) begin
      nb = 3'(MAX_CODE_BYTES);
    end else begin
      nb = cfg.max_bytes;
    end
    if (cfg.high_codes == 9'd0) begin
      h = 9'd1;
    end else if (cfg.high_codes > 9'd256) begin
      h = 9'd256;
    end else begin
      h = cfg.high_codes;
    end
    l = 9'd256 - h;
    prod = {8'd0, digit_factor} * {33'd0, data_byte};
    sum_next = partial_sum + prod;
    df_mul = {9'd0, digit_factor} * {33'd0, h};
    seen_next = bytes_seen + 3'd1;
    done = ({1'b0, data_byte} < l) || (seen_next >= nb);
    clr_eff = clr_pend | clear_delta;
  end

  assign push = accept && (done || last_byte);

  always_comb begin
    push_data.clr = clr_eff;
    if (!done) begin
      push_data.status = ST_TRUNCATED;
      push_data.sum = 32'd0;
    end else if (|sum_next[40:32]) begin
      push_data.status = ST_OVERFLOW;
      push_data.sum = 32'd0;
    end else begin
      push_data.status = ST_OK;
      push_data.sum = sum_next[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_sum <= '0;
      digit_factor <= 33'd1;
      bytes_seen <= '0;
      clr_pend <= 1'b0;
    end else if (accept) begin
      if (push) begin
        partial_sum <= '0;
        digit_factor <= 33'd1;
        bytes_seen <= '0;
        clr_pend <= 1'b0;
      end else begin
        partial_sum <= sum_next;
        digit_factor <= df_mul[32:0];
        bytes_seen <= seen_next;
        // clear only matters when a value is delivered, so hold it until then
        clr_pend <= clr_eff;
      end
    end
  end

endmodule

// File: sv/bhsd_queue.sv
module bhsd_queue #(
  parameter int DEPTH = bhsd_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  bhsd_pkg::event_t        push_data,
  input  logic                    pop,
  output bhsd_pkg::event_t        head,
  output logic                    head_valid,
  output logic                    ready,
  output bhsd_pkg::queue_status_t status
);
  import bhsd_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  event_t        entries [DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          full;
  logic          empty;
  logic          do_push;
  logic          do_pop;

  assign full = (count == FULL_CNT);
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = entries[rd_ptr];
  assign head_valid = !empty;
  assign ready = !full;

  always_comb begin
    status.full = full;
    status.empty = empty;
    status.push = do_push;
    status.pop = do_pop;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/bhsd_back.sv
module bhsd_back (
  input  logic             clk,
  input  logic             rst,
  input  bhsd_pkg::cfg_t   cfg,
  input  bhsd_pkg::event_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,
  output logic [1:0]       m_tuser
);
  import bhsd_pkg::*;

  logic        s1_valid;
  logic [1:0]  s1_status;
  logic        s1_clr;
  logic [31:0] s1_val;
  logic [31:0] previous_value;

  logic        s1_ready;
  logic        s2_ready;
  logic [1:0]  s;
  logic [1:0]  m;
  logic [31:0] q;
  logic [31:0] folded;
  logic [31:0] prev_eff;
  logic [31:0] with_delta;

  assign s2_ready = !m_tvalid || m_tready;
  assign s1_ready = !s1_valid || s2_ready;
  assign pop = head_valid && s1_ready;

  // sign fold on the queue head
  always_comb begin
    s = (cfg.sign_bits == 2'd3) ? 2'd2 : cfg.sign_bits;
    m = (s == 2'd0) ? 2'd0 : ((s == 2'd1) ? 2'd1 : 2'd3);
    q = head.sum >> s;
    if (s == 2'd0) begin
      folded = head.sum;
    end else if ((head.sum[1:0] & m) < m) begin
      folded = head.sum - q;
    end else begin
      folded = ~q;
    end
  end

  always_comb begin
    prev_eff = s1_clr ? 32'd0 : previous_value;
    with_delta = cfg.delta_mode ? s1_val + prev_eff : s1_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_status <= head.status;
      s1_clr <= head.clr;
      s1_val <= folded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      previous_value <= '0;
    end else begin
      if (s2_ready) begin
        m_tvalid <= s1_valid;
      end
      if (s1_valid && s2_ready) begin
        if (s1_status == ST_OK && cfg.delta_mode) begin
          previous_value <= with_delta;
        end else begin
          previous_value <= prev_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      m_tuser <= s1_status;
      m_tdata <= (s1_status == ST_OK) ? with_delta : 32'd0;
    end
  end

endmodule

// File: sv/bhsd_varint_decoder.sv
// a byte that ends a value has its result written into the queue, then the back's s1 registers, then the output
// throughput: one byte per cycle while the queue is not full; the digit factor multiply in the front is combinational
// a queue of QUEUE_DEPTH entries (four by default) lets the front keep taking bytes while results wait on m_tready
// reset (synchronous, rst high): config back to B=5 H=64 S=0 D=0, partial value,
// previous value and queue cleared, no result pending
module bhsd_varint_decoder #(
  parameter int QUEUE_DEPTH = bhsd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic                            s_tlast,   // last_byte
  input  logic [0:0]                      s_tuser,   // [0] clear_delta
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // [31:0] decoded_value
  output logic [1:0]                      m_tuser,   // [1:0] status
  input  logic                            cfg_we,
  input  logic [bhsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bhsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bhsd_pkg::*;

  cfg_t          cfg;
  logic          accept;
  logic          push;
  event_t        push_data;
  event_t        head;
  logic          head_valid;
  logic          pop;
  queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_bytes <= MAX_BYTES_RST;
      cfg.high_codes <= HIGH_CODES_RST;
      cfg.sign_bits <= SIGN_BITS_RST;
      cfg.delta_mode <= DELTA_MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_BYTES:  cfg.max_bytes <= cfg_wdata[2:0];
        CFG_HIGH_CODES: cfg.high_codes <= cfg_wdata[8:0];
        CFG_SIGN_BITS:  cfg.sign_bits <= cfg_wdata[1:0];
        CFG_DELTA_MODE: cfg.delta_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  bhsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .data_byte   (s_tdata),
    .last_byte   (s_tlast),
    .clear_delta (s_tuser[0]),
    .push        (push),
    .push_data   (push_data)
  );

  bhsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .ready      (s_tready),
    .status     (q_status)
  );

  bhsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 32'd0))
    else $error("error status with nonzero value");

  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |-> q_status.push)
    else $error("last byte gave no result");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (q_status.empty && q_status.push) |=> !q_status.empty)
    else $error("queue lost a request");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (q_status.full && !q_status.pop) |=> q_status.full)
    else $error("queue drained without pop");

endmodule
